>>> rtl/lpd_pkg.sv
// Package for the length-prefix deframer: result type, error codes and constants.
// No dependencies; used by the parser, the top level and the checker.
package lpd_pkg;

  localparam logic [15:0] MIN_LENGTH     = 16'd2;
  localparam logic [15:0] MAX_SIZE_RESET = 16'hFFFF;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_SHORT = 2'd1;
  localparam logic [1:0] ERR_LONG  = 2'd2;

  typedef struct packed {
    logic [7:0]  data_out;
    logic        is_header;
    logic        message_end;
    logic [1:0]  frame_error;
    logic        dropped;
    logic [15:0] message_length;
  } result_t;

endpackage

>>> rtl/lpd_in_if.sv
// Input byte channel of the length-prefix deframer: valid, ready and one raw byte.
// No dependencies.
interface lpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_in;

  modport source (output valid, output data_in, input ready);
  modport sink (input valid, input data_in, output ready);
endinterface

>>> rtl/lpd_out_if.sv
// Result channel of the length-prefix deframer: valid, ready and the per-byte result.
// Depends on nothing beyond its own signal list.
interface lpd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_out;
  logic        is_header;
  logic        message_end;
  logic [1:0]  frame_error;
  logic        dropped;
  logic [15:0] message_length;

  modport source (output valid, output data_out, output is_header, output message_end,
                  output frame_error, output dropped, output message_length, input ready);
  modport sink (input valid, input data_out, input is_header, input message_end,
                input frame_error, input dropped, input message_length, output ready);
endinterface

>>> rtl/lpd_parser.sv
// Framing state and per-byte result logic of the length-prefix deframer.
// Depends on lpd_pkg for the result type, error codes and minimum length.
module lpd_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         data_in,
  input  logic [15:0]        max_size,
  output lpd_pkg::result_t   result
);

  logic [7:0]  low_length_byte;
  logic [7:0]  low_length_byte_next;
  logic [15:0] declared_size;
  logic [15:0] declared_size_next;
  logic [15:0] received_count;
  logic [15:0] received_count_next;
  logic        stream_stopped;
  logic        stream_stopped_next;
  logic [15:0] header_length;
  logic [15:0] count_inc;

  assign header_length = {data_in, low_length_byte};
  assign count_inc     = received_count + 16'd1;

  always_comb begin
    low_length_byte_next  = low_length_byte;
    declared_size_next    = declared_size;
    received_count_next   = received_count;
    stream_stopped_next   = stream_stopped;
    result.data_out       = data_in;
    result.is_header      = 1'b0;
    result.message_end    = 1'b0;
    result.frame_error    = lpd_pkg::ERR_NONE;
    result.dropped        = 1'b0;
    result.message_length = 16'd0;
    if (stream_stopped) begin
      result.dropped = 1'b1;
    end else if (received_count == 16'd0) begin
      low_length_byte_next = data_in;
      received_count_next  = 16'd1;
      result.is_header     = 1'b1;
    end else if (received_count == 16'd1) begin
      result.is_header      = 1'b1;
      result.message_length = header_length;
      received_count_next   = 16'd0;
      declared_size_next    = 16'd0;
      if (header_length < lpd_pkg::MIN_LENGTH) begin
        result.frame_error  = lpd_pkg::ERR_SHORT;
        stream_stopped_next = 1'b1;
      end else if (header_length > max_size) begin
        result.frame_error  = lpd_pkg::ERR_LONG;
        stream_stopped_next = 1'b1;
      end else if (header_length == lpd_pkg::MIN_LENGTH) begin
        result.message_end = 1'b1;
      end else begin
        declared_size_next  = header_length;
        received_count_next = 16'd2;
      end
    end else begin
      result.message_length = declared_size;
      received_count_next   = count_inc;
      if (count_inc >= declared_size) begin
        result.message_end  = 1'b1;
        received_count_next = 16'd0;
        declared_size_next  = 16'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_length_byte <= 8'd0;
      declared_size   <= 16'd0;
      received_count  <= 16'd0;
      stream_stopped  <= 1'b0;
    end else if (accept) begin
      low_length_byte <= low_length_byte_next;
      declared_size   <= declared_size_next;
      received_count  <= received_count_next;
      stream_stopped  <= stream_stopped_next;
    end
  end

endmodule

>>> rtl/length_prefix_deframer.sv
// Top level of the length-prefix deframer: channels, maximum-size register, result register.
// Depends on lpd_pkg, lpd_in_if, lpd_out_if and lpd_parser.
//
// The block takes a byte stream on rx and splits it into messages, each led by a
// 2-byte little-endian length that counts the header bytes too. Every byte accepted
// on rx gives exactly one transaction on tx, carrying the byte, header and end marks,
// the declared length and an error or drop status.
// The maximum message size is written through cfg_write and cfg_data; the user must write
// it only while idle, as the block does not enforce this. tx valid follows an rx transaction
// in the next cycle; the single result register allows one byte per cycle unless tx stalls.
// When tx stalls, the held result stays on tx and rx takes no further byte until
// the result is taken; a taken result frees rx in the same cycle.
// Reset clears the framing state, sets the maximum size to 65535 and empties the
// result register. A length error stops the stream, and every later byte is passed
// with the dropped mark until the next reset.
module length_prefix_deframer (
  input  logic        clk,
  input  logic        rst,
  lpd_in_if.sink      rx,
  lpd_out_if.source   tx,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data
);

  logic [15:0]      max_size;
  logic             accept;
  logic             out_valid;
  lpd_pkg::result_t result;
  lpd_pkg::result_t out_result;

  assign rx.ready = !out_valid || tx.ready;
  assign accept   = rx.valid && rx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_size <= lpd_pkg::MAX_SIZE_RESET;
    end else if (cfg_write) begin
      max_size <= cfg_data;
    end
  end

  lpd_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .data_in  (rx.data_in),
    .max_size (max_size),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (tx.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_result <= result;
    end
  end

  assign tx.valid          = out_valid;
  assign tx.data_out       = out_result.data_out;
  assign tx.is_header      = out_result.is_header;
  assign tx.message_end    = out_result.message_end;
  assign tx.frame_error    = out_result.frame_error;
  assign tx.dropped        = out_result.dropped;
  assign tx.message_length = out_result.message_length;

endmodule

>>> rtl/lpd_checker.sv
// Port-level assertions for the length-prefix deframer, attached by a bind statement.
// Depends on length_prefix_deframer and the lpd_pkg error codes.
module lpd_checker (
  input logic        clk,
  input logic        rst,
  input logic        rx_valid,
  input logic        rx_ready,
  input logic        tx_valid,
  input logic        tx_ready,
  input logic [7:0]  data_out,
  input logic        is_header,
  input logic        message_end,
  input logic [1:0]  frame_error,
  input logic        dropped,
  input logic [15:0] message_length
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    tx_valid && !tx_ready |=> tx_valid && $stable(data_out) && $stable(message_length))
    else $error("Stalled result changed.");

  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    rx_valid && rx_ready |=> tx_valid)
    else $error("Accepted byte gave no result.");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !tx_valid |-> rx_ready)
    else $error("Input stalled with an empty result register.");

  a_error_on_header: assert property (@(posedge clk) disable iff (rst)
    tx_valid && frame_error != lpd_pkg::ERR_NONE |-> is_header && !message_end && !dropped)
    else $error("Length error outside a second header byte.");

  a_dropped_clean: assert property (@(posedge clk) disable iff (rst)
    tx_valid && dropped |-> !is_header && !message_end && frame_error == lpd_pkg::ERR_NONE
      && message_length == 16'd0)
    else $error("Dropped byte carries framing marks.");

endmodule

bind length_prefix_deframer lpd_checker u_lpd_checker (
  .clk            (clk),
  .rst            (rst),
  .rx_valid       (rx.valid),
  .rx_ready       (rx.ready),
  .tx_valid       (tx.valid),
  .tx_ready       (tx.ready),
  .data_out       (tx.data_out),
  .is_header      (tx.is_header),
  .message_end    (tx.message_end),
  .frame_error    (tx.frame_error),
  .dropped        (tx.dropped),
  .message_length (tx.message_length)
);
